@@ rtl/core/soc_pkg.sv @@
// Shared types, register codes and constants for the spectrum occupancy detector.
`default_nettype none

package soc_pkg;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_DB   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_HOT_BINS   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PERSIST_FRAMES = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_GATE_SECONDS   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_COOLDOWN_MS    = 3'd4;

	// Register reset values
	localparam logic signed [7:0] THRESHOLD_RST = -8'sd60;
	localparam logic [8:0]        MIN_HOT_RST   = 9'd8;
	localparam logic [7:0]        PERSIST_RST   = 8'd5;
	localparam logic [7:0]        GATE_SEC_RST  = 8'd3;
	localparam logic [15:0]       COOLDOWN_RST  = 16'd5000;

	// Gate limit in ms: gate_seconds * 1000 fits in 18 bits
	localparam int          GATE_LIMIT_W = 18;
	localparam logic [9:0]  MS_PER_SEC   = 10'd1000;

	// Saturation limits
	localparam logic [8:0]  HOT_MAX     = 9'h1FF;
	localparam logic [7:0]  PERSIST_MAX = 8'hFF;
	localparam logic [31:0] GATE_MAX    = 32'hFFFF_FFFF;

	// Frame phase codes
	localparam logic [1:0] PHASE_SCAN      = 2'd0;
	localparam logic [1:0] PHASE_CANDIDATE = 2'd1;
	localparam logic [1:0] PHASE_GATE      = 2'd2;

	typedef struct packed {
		logic signed [7:0] bin_level;
		logic              last_bin;
		logic [31:0]       frame_time_ms;
	} soc_in_t;

	typedef struct packed {
		logic [8:0]  hot_count;
		logic [1:0]  phase;
		logic [7:0]  persist_level;
		logic [31:0] gate_time_ms;
		logic        alert_on;
		logic        beep_start;
		logic        beep_stop;
	} soc_out_t;

endpackage

`default_nettype wire

@@ rtl/core/spectrum_occupancy_detector.sv @@
// Top level of the spectrum occupancy detector: bin counting and frame decision.
`default_nettype none

// Channel   Dir  Handshake           Word
// in        in   in_valid/in_stall   soc_in_t  (one spectrum bin)
// out       out  out_valid/out_stall soc_out_t (one frame result, on last bin only)
// cfg       in   cfg_wr_en           cfg_index/cfg_data
//
// One bin per cycle unless a stalled result holds a last bin: each word is held in the input
// register, where the bin compare and, on the last bin, the frame decision are done into the result register.
// out_valid rises once the last bin passes from the input register into the result register.
// Reset clears all counters, timers and the alert and loads register defaults.
// A stalled result holds only last bins back; other bins keep flowing.

module spectrum_occupancy_detector
	import soc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output      logic                   in_stall,
	input  wire soc_in_t                in_data,
	output      logic                   out_valid,
	input  wire logic                   out_stall,
	output      soc_out_t               out_data,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	// Configuration registers
	logic signed [7:0]       threshold_q;
	logic [8:0]              min_hot_q;
	logic [7:0]              persist_frames_q;
	logic [GATE_LIMIT_W-1:0] gate_limit_q;
	logic [15:0]             cooldown_cfg_q;

	// Detector state
	logic [8:0]  hot_accum_q;
	logic [7:0]  persist_q;
	logic [31:0] gate_q;
	logic [15:0] cooldown_q;
	logic [31:0] prev_time_q;
	logic        first_frame_q;
	logic        alert_q;

	// Pipeline registers
	logic     valid_s1;
	soc_in_t  word_s1;
	logic     out_valid_q;
	soc_out_t out_word_q;

	// Frame close logic
	logic        slot_free;
	logic        advance;
	logic        accept;
	logic        bin_hot;
	logic [8:0]  hot_next;
	logic [31:0] dt;
	logic [15:0] cool_dec;
	logic        detected;
	logic [7:0]  persist_next;
	logic        in_gate;
	logic [32:0] gate_sum;
	logic [31:0] gate_add;
	logic        gate_reached;
	logic        beep_fire;
	logic        stop_fire;
	logic [31:0] gate_next;
	logic        alert_next;
	logic [15:0] cool_next;
	logic [1:0]  phase_next;

	// Handshake
	assign slot_free = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && (!word_s1.last_bin || slot_free);
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

	// Count this bin, saturating
	always_comb begin
		bin_hot  = word_s1.bin_level > threshold_q;
		hot_next = hot_accum_q + ((bin_hot && hot_accum_q != HOT_MAX) ? 9'd1 : 9'd0);
	end

	// Elapsed time and cooldown
	always_comb begin
		dt = first_frame_q ? 32'd0 : word_s1.frame_time_ms - prev_time_q;
		if ({16'd0, cooldown_q} > dt) begin
			cool_dec = cooldown_q - dt[15:0];
		end else begin
			cool_dec = 16'd0;
		end
	end

	// Persistence, gate timer and alert
	always_comb begin
		detected     = hot_next >= min_hot_q;
		persist_next = (persist_q != PERSIST_MAX) ? persist_q + 8'd1 : persist_q;
		in_gate      = persist_next >= persist_frames_q;
		gate_sum     = {1'b0, gate_q} + {1'b0, dt};
		gate_add     = gate_sum[32] ? GATE_MAX : gate_sum[31:0];
		gate_reached = gate_add >= {{(32-GATE_LIMIT_W){1'b0}}, gate_limit_q};
		beep_fire    = 1'b0;
		stop_fire    = 1'b0;
		cool_next    = cool_dec;
		if (!detected) begin
			persist_next = 8'd0;
			gate_next    = 32'd0;
			alert_next   = 1'b0;
			stop_fire    = alert_q;
			phase_next   = PHASE_SCAN;
		end else if (!in_gate) begin
			gate_next  = 32'd0;
			alert_next = alert_q;
			phase_next = PHASE_CANDIDATE;
		end else begin
			gate_next  = gate_add;
			alert_next = alert_q || gate_reached;
			phase_next = PHASE_GATE;
			if (gate_reached && cool_dec == 16'd0) begin
				beep_fire = 1'b1;
				cool_next = cooldown_cfg_q;
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q      <= THRESHOLD_RST;
			min_hot_q        <= MIN_HOT_RST;
			persist_frames_q <= PERSIST_RST;
			gate_limit_q     <= GATE_LIMIT_W'(GATE_SEC_RST) * GATE_LIMIT_W'(MS_PER_SEC);
			cooldown_cfg_q   <= COOLDOWN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_THRESHOLD_DB:   threshold_q      <= cfg_data[7:0];
				CFG_MIN_HOT_BINS:   min_hot_q        <= cfg_data[8:0];
				CFG_PERSIST_FRAMES: persist_frames_q <= cfg_data[7:0];
				CFG_GATE_SECONDS:   gate_limit_q     <=
					GATE_LIMIT_W'(cfg_data[7:0]) * GATE_LIMIT_W'(MS_PER_SEC);
				CFG_COOLDOWN_MS:    cooldown_cfg_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_data;
		end
	end

	// Advance detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hot_accum_q   <= 9'd0;
			persist_q     <= 8'd0;
			gate_q        <= 32'd0;
			cooldown_q    <= 16'd0;
			prev_time_q   <= 32'd0;
			first_frame_q <= 1'b1;
			alert_q       <= 1'b0;
		end else if (advance) begin
			if (word_s1.last_bin) begin
				hot_accum_q   <= 9'd0;
				persist_q     <= persist_next;
				gate_q        <= gate_next;
				cooldown_q    <= cool_next;
				prev_time_q   <= word_s1.frame_time_ms;
				first_frame_q <= 1'b0;
				alert_q       <= alert_next;
			end else begin
				hot_accum_q <= hot_next;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && word_s1.last_bin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_s1.last_bin) begin
			out_word_q.hot_count     <= hot_next;
			out_word_q.phase         <= phase_next;
			out_word_q.persist_level <= persist_next;
			out_word_q.gate_time_ms  <= gate_next;
			out_word_q.alert_on      <= alert_next;
			out_word_q.beep_start    <= beep_fire;
			out_word_q.beep_stop     <= stop_fire;
		end
	end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the spectrum occupancy detector: bin stream in, frame words out.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import soc_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 10;
	localparam int DRAIN_CYCLES  = 6;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int IDLE_PCT      = 15;

	localparam logic [8:0]  HOT_SAT     = 9'h1FF;
	localparam logic [7:0]  PERSIST_SAT = 8'hFF;
	localparam logic [31:0] GATE_SAT    = 32'hFFFF_FFFF;
	localparam logic [31:0] MS_IN_SEC   = 32'd1000;

	localparam logic [CFG_INDEX_W-1:0] CFG_LAST_INDEX = CFG_COOLDOWN_MS;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_stall;
	soc_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	soc_out_t out_data;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	spectrum_occupancy_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Register copies as last written
	logic signed [7:0] thr_db;
	logic [8:0]        min_hot;
	logic [7:0]        persist_req;
	logic [7:0]        gate_sec;
	logic [15:0]       cooldown;

	// Detector state
	logic [8:0]  hot_acc;
	logic [7:0]  persist;
	logic [31:0] gate_ms;
	logic [15:0] cool_left;
	logic [31:0] prev_ms;
	bit          first_frame;
	bit          alert;

	soc_in_t  bin_queue[$];
	soc_out_t awaited_frames[$];

	bit          in_taken;
	int          idle_pct  = IDLE_PCT;
	int          stall_pct = IDLE_PCT;
	int          errors, cycles, bins_sent, frames_checked, settings_used;
	int          alerts_seen, beeps_seen, stops_seen;
	logic [31:0] clock_ms;

	// Advance the detector by one bin; return 1 with the frame word on a last bin
	function bit track_bin(input soc_in_t w, output soc_out_t r);
		logic [8:0]  hot;
		logic [31:0] dt;
		logic [32:0] gate_sum;
		r = '0;
		if ($signed(w.bin_level) > $signed(thr_db) && hot_acc != HOT_SAT)
			hot_acc = hot_acc + 9'd1;
		if (!w.last_bin)
			return 1'b0;
		hot = hot_acc;
		hot_acc = '0;

		// Wrapping elapsed time; the first frame after reset counts as zero
		dt = first_frame ? 32'd0 : w.frame_time_ms - prev_ms;
		prev_ms = w.frame_time_ms;
		first_frame = 1'b0;

		if ({16'd0, cool_left} > dt)
			cool_left = cool_left - dt[15:0];
		else
			cool_left = '0;

		r.hot_count = hot;
		if (hot < min_hot) begin
			// Miss: drop persistence, gate and alert
			persist = '0;
			gate_ms = '0;
			r.beep_stop = alert;
			alert = 1'b0;
			r.phase = PHASE_SCAN;
		end else begin
			if (persist != PERSIST_SAT)
				persist = persist + 8'd1;
			if (persist < persist_req) begin
				gate_ms = '0;
				r.phase = PHASE_CANDIDATE;
			end else begin
				r.phase = PHASE_GATE;
				gate_sum = {1'b0, gate_ms} + {1'b0, dt};
				gate_ms = gate_sum[32] ? GATE_SAT : gate_sum[31:0];
				if (gate_ms >= {24'd0, gate_sec} * MS_IN_SEC) begin
					alert = 1'b1;
					if (cool_left == '0) begin
						cool_left = cooldown;
						r.beep_start = 1'b1;
					end
				end
			end
		end
		r.persist_level = persist;
		r.gate_time_ms = gate_ms;
		r.alert_on = alert;
		return 1'b1;
	endfunction

	task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Pick a level on the requested side of the current threshold; a hot level is only given below a zero threshold
	function logic signed [7:0] pick_level(input bit want_hot);
		int t;
		int v;
		t = thr_db;
		if (want_hot && t < 0)
			v = t + 1 + int'($urandom_range(-t - 1, 0));
		else if ($urandom_range(9) == 0)
			v = t;
		else
			v = -128 + int'($urandom_range(t + 128, 0));
		return v[7:0];
	endfunction

	task add_bin(input logic signed [7:0] lvl, input bit last, input logic [31:0] ts);
		soc_in_t w;
		w.bin_level = lvl;
		w.last_bin = last;
		w.frame_time_ms = ts;
		bin_queue.push_back(w);
	endtask

	// Queue one frame; the stamp advances by a random step
	task add_frame(input int nbins, input int hot_pct, input int unsigned step_lo,
			input int unsigned step_hi);
		clock_ms = clock_ms + $urandom_range(step_hi, step_lo);
		for (int i = 0; i < nbins - 1; i++)
			add_bin(pick_level($urandom_range(99) < hot_pct), 1'b0, $urandom());
		add_bin(pick_level($urandom_range(99) < hot_pct), 1'b1, clock_ms);
	endtask

	task write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
		CFG_THRESHOLD_DB:   thr_db      = val[7:0];
		CFG_MIN_HOT_BINS:   min_hot     = val[8:0];
		CFG_PERSIST_FRAMES: persist_req = val[7:0];
		CFG_GATE_SECONDS:   gate_sec    = val[7:0];
		CFG_COOLDOWN_MS:    cooldown    = val;
		default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Write every register, junk in the unused upper bits, plus one unmapped index
	task configure(input logic signed [7:0] thr, input logic [8:0] mh, input logic [7:0] pf,
			input logic [7:0] gs, input logic [15:0] cd);
		logic [15:0] junk;
		junk = 16'($urandom());
		write_reg(CFG_THRESHOLD_DB, {junk[15:8], thr});
		write_reg(CFG_MIN_HOT_BINS, {junk[6:0], mh});
		write_reg(CFG_PERSIST_FRAMES, {junk[7:0], pf});
		write_reg(CFG_GATE_SECONDS, {junk[11:4], gs});
		write_reg(CFG_COOLDOWN_MS, cd);
		write_reg(CFG_INDEX_W'($urandom_range(2**CFG_INDEX_W - 1, CFG_LAST_INDEX + 1)),
			CFG_DATA_W'($urandom()));
		settings_used++;
	endtask

	// Hold until every queued bin is in and every frame word is out
	task drain;
		while (bin_queue.size() != 0 || in_valid || awaited_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Input side: record accepted words and predict
	always @(posedge clk) begin
		soc_out_t frame_word;
		if (arst_n && in_valid && !in_stall) begin
			in_taken = 1'b1;
			bins_sent++;
			if (track_bin(in_data, frame_word))
				awaited_frames.push_back(frame_word);
		end
	end

	// Driver: present the next word once the current one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (bin_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
				in_data  <= bin_queue.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		in_taken = 1'b0;
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	// Monitor: compare each frame word with the oldest prediction
	always @(posedge clk) begin
		soc_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_frames.size() == 0) begin
				$error("frame word with none expected: %p", out_data);
				errors++;
			end else begin
				want = awaited_frames.pop_front();
				check_field("hot_count", want.hot_count, out_data.hot_count);
				check_field("phase", want.phase, out_data.phase);
				check_field("persist_level", want.persist_level, out_data.persist_level);
				check_field("gate_time_ms", want.gate_time_ms, out_data.gate_time_ms);
				check_field("alert_on", want.alert_on, out_data.alert_on);
				check_field("beep_start", want.beep_start, out_data.beep_start);
				check_field("beep_stop", want.beep_stop, out_data.beep_stop);
				frames_checked++;
				alerts_seen += want.alert_on;
				beeps_seen  += want.beep_start;
				stops_seen  += want.beep_stop;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles, %0d frame words pending",
				cycles, awaited_frames.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic signed [7:0] r_thr;
		int                target;
		bit                busy;

		thr_db      = THRESHOLD_RST;
		min_hot     = MIN_HOT_RST;
		persist_req = PERSIST_RST;
		gate_sec    = GATE_SEC_RST;
		cooldown    = COOLDOWN_RST;
		hot_acc     = '0;
		persist     = '0;
		gate_ms     = '0;
		cool_left   = '0;
		prev_ms     = '0;
		first_frame = 1'b1;
		alert       = 1'b0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed: level extremes, threshold edge, stamp wrap, zero gate, cooldown, miss
		configure(-8'sd60, 9'd2, 8'd1, 8'd0, 16'd1000);
		add_bin(-8'sd60, 1'b0, $urandom());
		add_bin(-8'sd59, 1'b0, $urandom());
		add_bin(8'sd0, 1'b1, 32'hFFFF_FF00);
		add_bin(-8'sd128, 1'b0, $urandom());
		add_bin(-8'sd1, 1'b0, $urandom());
		add_bin(8'sd0, 1'b1, 32'h0000_0100);
		add_bin(-8'sd128, 1'b1, 32'h0000_0358);
		add_bin(-8'sd128, 1'b1, 32'h0000_0400);
		add_bin(8'sd0, 1'b0, $urandom());
		add_bin(-8'sd30, 1'b1, 32'h0000_0500);
		clock_ms = 32'h0000_0500;
		drain();

		// Settings after reset: candidate build-up, gate and cooldown
		configure(THRESHOLD_RST, MIN_HOT_RST, PERSIST_RST, GATE_SEC_RST, COOLDOWN_RST);
		target = bin_queue.size() + 400;
		while (bin_queue.size() < target) begin
			busy = $urandom_range(99) < 80;
			add_frame($urandom_range(16, 8), busy ? 85 : 5, 100, 1500);
		end
		drain();

		// Low extremes with no idling: every frame detected, counters saturate
		idle_pct  = 0;
		stall_pct = 0;
		configure(-8'sd128, 9'd0, 8'd0, 8'd0, 16'd0);
		clock_ms = 32'hFFFF_0000;
		for (int i = 0; i < 300; i++) begin
			if (i == 120)
				add_frame(600, 95, 0, 1000);
			else
				add_frame($urandom_range(2, 1), 50, 0, 32'hFFFF_FFFF);
		end
		drain();
		idle_pct  = IDLE_PCT;
		stall_pct = IDLE_PCT;

		// High extremes: nothing can be hot
		configure(8'sd0, 9'd256, 8'd255, 8'd255, 16'hFFFF);
		for (int i = 0; i < 10; i++)
			add_frame($urandom_range(4, 1), 100, 0, 5000);
		drain();

		// Random mid-range settings
		for (int p = 0; p < 3; p++) begin
			r_thr = 8'(-int'($urandom_range(100, 20)));
			configure(r_thr, 9'($urandom_range(6, 1)), 8'($urandom_range(4, 0)),
				8'($urandom_range(3, 0)), (p == 2) ? 16'hFFFF : 16'($urandom_range(8000, 0)));
			target = bin_queue.size() + 150;
			while (bin_queue.size() < target) begin
				busy = $urandom_range(99) < 75;
				add_frame($urandom_range(12, 4), busy ? 80 : 10, 50, 1200);
			end
			drain();
		end

		$display("%0d bins, %0d frame words checked over %0d register settings",
			bins_sent, frames_checked, settings_used);
		$display("alert frames %0d, beep starts %0d, beep stops %0d",
			alerts_seen, beeps_seen, stops_seen);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
